/* hw/rtl/tfb_pkg.sv */
package tfb_pkg;

  // Widths fixed by the item formats
  localparam int unsigned SUM_W      = 40;   // block / ring sums, covers WINDOW up to 64
  localparam int unsigned WINDOW_DEF = 10;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // pi/30 in Q0.32
  localparam logic [31:0] PWR_K = 32'd449767923;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_GAIN     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ADAPT_THR    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ADAPT_FAST   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ADAPT_SLOW   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_AB_ALPHA     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_AB_BETA      = 4'd7;

  // Filter mode codes
  localparam logic [2:0] MODE_BLOCK = 3'd0;
  localparam logic [2:0] MODE_RING  = 3'd1;
  localparam logic [2:0] MODE_EXP   = 3'd2;
  localparam logic [2:0] MODE_ADAPT = 3'd3;
  localparam logic [2:0] MODE_TRACK = 3'd4;
  localparam logic [2:0] MODE_NONE  = 3'd5;

  // Register reset values
  localparam logic [2:0]  RST_FILTER_MODE = MODE_NONE;
  localparam logic [16:0] RST_EXP_GAIN    = 17'd6554;
  localparam logic [30:0] RST_ADAPT_THR   = 31'd98304;
  localparam logic [16:0] RST_ADAPT_FAST  = 17'd58982;
  localparam logic [16:0] RST_ADAPT_SLOW  = 17'd1966;
  localparam logic [24:0] RST_AB_ALPHA    = 25'd954133;
  localparam logic [24:0] RST_AB_BETA     = 25'd27931;

  typedef struct packed {
    logic signed [31:0] torque_sample;
    logic signed [31:0] speed_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] filtered_torque;
    logic [47:0]        shaft_power;
  } out_item_t;

  // Item between front and back: corrected torque and speed
  typedef struct packed {
    logic signed [31:0] corr_torque;
    logic signed [31:0] speed;
  } q_item_t;

  typedef struct packed {
    logic [2:0]         filter_mode;
    logic signed [31:0] zero_offset;
    logic [16:0]        exp_gain;
    logic [30:0]        adapt_threshold;
    logic [16:0]        adapt_fast_gain;
    logic [16:0]        adapt_slow_gain;
    logic [24:0]        ab_alpha;
    logic [24:0]        ab_beta;
  } cfg_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_DIFF, BK_RING, BK_MUL, BK_UPD, BK_DIV,
    BK_PW0, BK_PW1, BK_PW2, BK_PW3, BK_OUT
  } back_st_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return x[31:0];
    end
  endfunction

endpackage

/* hw/rtl/tfb_front.sv */
module tfb_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tfb_pkg::cfg_t        cfg,
  input  logic                 in_push,
  output logic                 in_full,
  input  tfb_pkg::in_item_t    in_data,
  output logic                 q_valid,
  input  logic                 q_take,
  output tfb_pkg::q_item_t     q_data
);

  tfb_pkg::q_item_t   q_mem_r [2];
  logic               wr_ptr_r, rd_ptr_r;
  logic [1:0]         cnt_r;
  logic               wr_en;
  logic signed [32:0] sum;
  tfb_pkg::q_item_t   entry;

  // Correct the torque by the zero offset, saturating
  always_comb begin
    sum = 33'(in_data.torque_sample) + 33'(cfg.zero_offset);
    entry.corr_torque = tfb_pkg::sat32(64'(sum));
    entry.speed       = in_data.speed_sample;
  end

  assign in_full = (cnt_r == 2'd2);
  assign wr_en   = in_push && !in_full;
  assign q_valid = (cnt_r != 2'd0);
  assign q_data  = q_mem_r[rd_ptr_r];

  // Hold items for the back end
  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_mem_r[wr_ptr_r] <= entry;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_take) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(wr_en) - 2'(q_take);
    end
  end

endmodule

/* hw/rtl/tfb_div.sv */
module tfb_div #(
  parameter int unsigned WINDOW = tfb_pkg::WINDOW_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [tfb_pkg::SUM_W-1:0]  dividend,
  output logic                              done,
  output logic signed [tfb_pkg::SUM_W-1:0]  quotient
);

  // The magnitude is at most 2^31 * WINDOW, so 38 bits for WINDOW up to 64.
  // Split it into two 19-bit digits; each digit step divides a number below
  // 2^25 by WINDOW with one reciprocal multiply (exact for that range).
  localparam int unsigned MAG_W  = 38;
  localparam int unsigned DIG_W  = 19;
  localparam int unsigned NUM_W  = 25;
  localparam int unsigned REM_W  = NUM_W - DIG_W;
  localparam int unsigned SHIFT  = NUM_W + $clog2(WINDOW);
  localparam int unsigned RCP_W  = NUM_W + 2;
  localparam int unsigned PROD_W = NUM_W + RCP_W;
  localparam logic [63:0] RCP_FULL =
    ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [RCP_W-1:0] RCP = RCP_FULL[RCP_W-1:0];

  logic [MAG_W-1:0]          mag_r;
  logic [NUM_W-1:0]          num_r;
  logic [DIG_W-1:0]          q_hi_r, q_lo_r;
  logic                      neg_r, done_r;
  logic [2:0]                step_r;
  logic [tfb_pkg::SUM_W-1:0] abs_in;
  logic [NUM_W-1:0]          mul_a;
  logic [PROD_W-1:0]         prod;
  logic [DIG_W-1:0]          q_dig;
  logic [DIG_W-1:0]          q_w;
  logic [DIG_W-1:0]          rem;
  logic [2*DIG_W-1:0]        quo;

  // Reciprocal multiply for the current digit, remainder of the high digit
  always_comb begin
    abs_in = dividend[tfb_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;
    mul_a  = step_r[0] ? NUM_W'(mag_r[MAG_W-1:DIG_W]) : num_r;
    prod   = PROD_W'(mul_a) * PROD_W'(RCP);
    q_dig  = prod[SHIFT +: DIG_W];
    q_w    = q_hi_r * DIG_W'(WINDOW);
    rem    = mag_r[MAG_W-1:DIG_W] - q_w;
  end

  // Advance the step chain: high digit, remainder, low digit, done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      step_r <= {step_r[1:0], start};
      done_r <= step_r[2];
    end
  end

  // Load magnitude, then fill in the quotient digits
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[tfb_pkg::SUM_W-1];
      mag_r <= abs_in[MAG_W-1:0];
    end
    if (step_r[0]) begin
      q_hi_r <= q_dig;
    end
    if (step_r[1]) begin
      num_r <= {rem[REM_W-1:0], mag_r[DIG_W-1:0]};
    end
    if (step_r[2]) begin
      q_lo_r <= q_dig;
    end
  end

  assign quo      = {q_hi_r, q_lo_r};
  assign done     = done_r;
  assign quotient = neg_r ? -$signed(tfb_pkg::SUM_W'(quo)) : $signed(tfb_pkg::SUM_W'(quo));

endmodule

/* hw/rtl/tfb_back.sv */
module tfb_back #(
  parameter int unsigned WINDOW = tfb_pkg::WINDOW_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tfb_pkg::cfg_t        cfg,
  input  logic                 q_valid,
  output logic                 q_take,
  input  tfb_pkg::q_item_t     q_data,
  output logic                 out_empty,
  input  logic                 out_pop,
  output tfb_pkg::out_item_t   out_data
);

  localparam int unsigned PTR_W = $clog2(WINDOW);
  localparam int unsigned CNT_W = $clog2(WINDOW + 1);
  localparam int unsigned SW    = tfb_pkg::SUM_W;

  tfb_pkg::back_st_t st_r, st_nxt;

  // Item and work registers
  logic signed [31:0] c_r, c_nxt;
  logic signed [31:0] spd_r, spd_nxt;
  logic [2:0]         mode_r, mode_nxt;
  logic signed [31:0] y_r, y_nxt;
  logic signed [33:0] fa_r, fa_nxt;
  logic signed [25:0] fb_r, fb_nxt;
  logic signed [59:0] fprod_r, fprod_nxt;
  logic signed [32:0] p_r, p_nxt;
  logic               second_r, second_nxt;
  logic [63:0]        pprod_r, pprod_nxt;
  logic [59:0]        pm_r, pm_nxt;
  logic [31:0]        pn_r, pn_nxt;
  logic [47:0]        power_r, power_nxt;

  // Filter state
  logic signed [SW-1:0] block_sum_r, block_sum_nxt;
  logic [CNT_W-1:0]     block_cnt_r, block_cnt_nxt;
  logic signed [31:0]   block_res_r, block_res_nxt;
  logic [PTR_W-1:0]     ring_ptr_r, ring_ptr_nxt;
  logic signed [SW-1:0] ring_total_r, ring_total_nxt;
  logic signed [31:0]   exp_r, exp_nxt;
  logic signed [31:0]   adapt_r, adapt_nxt;
  logic signed [31:0]   pos_r, pos_nxt;
  logic signed [31:0]   vel_r, vel_nxt;

  // Ring memory
  logic signed [31:0] ring_mem [WINDOW];
  logic [WINDOW-1:0]  ring_vld_r;
  logic signed [31:0] rd_r;
  logic               rd_vld_r;
  logic               rd_en, wr_en;
  logic [PTR_W-1:0]   np;

  // Output slot
  tfb_pkg::out_item_t out_r;
  logic               out_valid_r, out_valid_nxt;
  logic               out_load;

  // Divider hookup
  logic                 div_start, div_done;
  logic signed [SW-1:0] div_in, div_quo;

  // Multipliers
  logic signed [59:0] fmul;
  logic [31:0]        pa, pb;
  logic [63:0]        pmul;

  // Scratch
  logic signed [SW-1:0] sum_tmp;
  logic [CNT_W-1:0]     cnt_inc;
  logic signed [33:0]   dd, add;
  logic signed [63:0]   r16, r24;
  logic signed [31:0]   old, v_new;
  logic [31:0]          ac, as_v;
  logic [59:0]          acc;

  tfb_div #(.WINDOW(WINDOW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_in),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign fmul = fa_r * fb_r;
  assign pmul = pa * pb;
  assign np   = (ring_ptr_r == PTR_W'(WINDOW - 1)) ? '0 : ring_ptr_r + 1'b1;

  // Next state and datapath
  always_comb begin
    st_nxt         = st_r;
    c_nxt          = c_r;
    spd_nxt        = spd_r;
    mode_nxt       = mode_r;
    y_nxt          = y_r;
    fa_nxt         = fa_r;
    fb_nxt         = fb_r;
    fprod_nxt      = fprod_r;
    p_nxt          = p_r;
    second_nxt     = second_r;
    pprod_nxt      = pprod_r;
    pm_nxt         = pm_r;
    pn_nxt         = pn_r;
    power_nxt      = power_r;
    block_sum_nxt  = block_sum_r;
    block_cnt_nxt  = block_cnt_r;
    block_res_nxt  = block_res_r;
    ring_ptr_nxt   = ring_ptr_r;
    ring_total_nxt = ring_total_r;
    exp_nxt        = exp_r;
    adapt_nxt      = adapt_r;
    pos_nxt        = pos_r;
    vel_nxt        = vel_r;
    q_take         = 1'b0;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    div_start      = 1'b0;
    div_in         = '0;
    out_load       = 1'b0;
    pa             = '0;
    pb             = '0;
    sum_tmp        = '0;
    cnt_inc        = '0;
    dd             = '0;
    add            = '0;
    old            = '0;
    v_new          = '0;
    ac             = c_r[31] ? (~c_r + 32'd1) : c_r;
    as_v           = spd_r[31] ? (~spd_r + 32'd1) : spd_r;
    acc            = pm_r + 60'(pn_r);
    r16            = (64'(fprod_r) + 64'sd32768) >>> 16;
    r24            = (64'(fprod_r) + 64'sd8388608) >>> 24;

    unique case (st_r)
      tfb_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_take   = 1'b1;
          c_nxt    = q_data.corr_torque;
          spd_nxt  = q_data.speed;
          mode_nxt = cfg.filter_mode;
          st_nxt   = tfb_pkg::BK_DIFF;
        end
      end

      // Classify by mode and set up the filter step
      tfb_pkg::BK_DIFF: begin
        case (mode_r)
          tfb_pkg::MODE_BLOCK: begin
            sum_tmp = block_sum_r + SW'(c_r);
            cnt_inc = block_cnt_r + 1'b1;
            if (cnt_inc == CNT_W'(WINDOW)) begin
              div_start     = 1'b1;
              div_in        = sum_tmp;
              block_sum_nxt = '0;
              block_cnt_nxt = '0;
              st_nxt        = tfb_pkg::BK_DIV;
            end else begin
              block_sum_nxt = sum_tmp;
              block_cnt_nxt = cnt_inc;
              y_nxt         = block_res_r;
              st_nxt        = tfb_pkg::BK_PW0;
            end
          end
          tfb_pkg::MODE_RING: begin
            rd_en        = 1'b1;
            ring_ptr_nxt = np;
            st_nxt       = tfb_pkg::BK_RING;
          end
          tfb_pkg::MODE_EXP: begin
            fa_nxt = 34'(c_r) - 34'(exp_r);
            fb_nxt = $signed(26'(cfg.exp_gain));
            st_nxt = tfb_pkg::BK_MUL;
          end
          tfb_pkg::MODE_ADAPT: begin
            dd     = 34'(c_r) - 34'(adapt_r);
            add    = dd[33] ? -dd : dd;
            fa_nxt = dd;
            fb_nxt = (add > $signed(34'(cfg.adapt_threshold))) ?
                     $signed(26'(cfg.adapt_fast_gain)) : $signed(26'(cfg.adapt_slow_gain));
            st_nxt = tfb_pkg::BK_MUL;
          end
          tfb_pkg::MODE_TRACK: begin
            p_nxt      = 33'(pos_r) + 33'(vel_r);
            fa_nxt     = 34'(c_r) - 34'(p_nxt);
            fb_nxt     = $signed(26'(cfg.ab_alpha));
            second_nxt = 1'b0;
            st_nxt     = tfb_pkg::BK_MUL;
          end
          default: begin
            y_nxt  = c_r;
            st_nxt = tfb_pkg::BK_PW0;
          end
        endcase
      end

      // Swap the oldest ring entry for the new sample
      tfb_pkg::BK_RING: begin
        old            = rd_vld_r ? rd_r : 32'sd0;
        sum_tmp        = ring_total_r - SW'(old) + SW'(c_r);
        ring_total_nxt = sum_tmp;
        wr_en          = 1'b1;
        div_start      = 1'b1;
        div_in         = sum_tmp;
        st_nxt         = tfb_pkg::BK_DIV;
      end

      tfb_pkg::BK_MUL: begin
        fprod_nxt = fmul;
        st_nxt    = tfb_pkg::BK_UPD;
      end

      // Apply the rounded correction
      tfb_pkg::BK_UPD: begin
        case (mode_r)
          tfb_pkg::MODE_EXP: begin
            v_new   = tfb_pkg::sat32(64'(exp_r) + r16);
            exp_nxt = v_new;
            y_nxt   = v_new;
            st_nxt  = tfb_pkg::BK_PW0;
          end
          tfb_pkg::MODE_ADAPT: begin
            v_new     = tfb_pkg::sat32(64'(adapt_r) + r16);
            adapt_nxt = v_new;
            y_nxt     = v_new;
            st_nxt    = tfb_pkg::BK_PW0;
          end
          default: begin
            if (!second_r) begin
              v_new      = tfb_pkg::sat32(64'(p_r) + r24);
              pos_nxt    = v_new;
              y_nxt      = v_new;
              fb_nxt     = $signed(26'(cfg.ab_beta));
              second_nxt = 1'b1;
              st_nxt     = tfb_pkg::BK_MUL;
            end else begin
              vel_nxt = tfb_pkg::sat32(64'(vel_r) + r24);
              st_nxt  = tfb_pkg::BK_PW0;
            end
          end
        endcase
      end

      tfb_pkg::BK_DIV: begin
        if (div_done) begin
          v_new = tfb_pkg::sat32(64'(div_quo));
          y_nxt = v_new;
          if (mode_r == tfb_pkg::MODE_BLOCK) begin
            block_res_nxt = v_new;
          end
          st_nxt = tfb_pkg::BK_PW0;
        end
      end

      // Power: |c|*|speed|, then times pi/30 in two halves
      tfb_pkg::BK_PW0: begin
        pa        = ac;
        pb        = as_v;
        pprod_nxt = pmul;
        st_nxt    = tfb_pkg::BK_PW1;
      end
      tfb_pkg::BK_PW1: begin
        pa     = pprod_r[63:32];
        pb     = tfb_pkg::PWR_K;
        pm_nxt = pmul[59:0];
        st_nxt = tfb_pkg::BK_PW2;
      end
      tfb_pkg::BK_PW2: begin
        pa     = pprod_r[31:0];
        pb     = tfb_pkg::PWR_K;
        pn_nxt = pmul[63:32];
        st_nxt = tfb_pkg::BK_PW3;
      end
      tfb_pkg::BK_PW3: begin
        // the product stays below 2^44, so the 48-bit limit is never hit
        power_nxt = 48'(acc[59:16]);
        st_nxt    = tfb_pkg::BK_OUT;
      end

      tfb_pkg::BK_OUT: begin
        if (!out_valid_r || out_pop) begin
          out_load = 1'b1;
          st_nxt   = tfb_pkg::BK_IDLE;
        end
      end

      default: st_nxt = tfb_pkg::BK_IDLE;
    endcase

    out_valid_nxt = out_load ? 1'b1 : (out_pop ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= tfb_pkg::BK_IDLE;
      out_valid_r  <= 1'b0;
      block_sum_r  <= '0;
      block_cnt_r  <= '0;
      block_res_r  <= '0;
      ring_ptr_r   <= '0;
      ring_total_r <= '0;
      exp_r        <= '0;
      adapt_r      <= '0;
      pos_r        <= '0;
      vel_r        <= '0;
    end else begin
      st_r         <= st_nxt;
      out_valid_r  <= out_valid_nxt;
      block_sum_r  <= block_sum_nxt;
      block_cnt_r  <= block_cnt_nxt;
      block_res_r  <= block_res_nxt;
      ring_ptr_r   <= ring_ptr_nxt;
      ring_total_r <= ring_total_nxt;
      exp_r        <= exp_nxt;
      adapt_r      <= adapt_nxt;
      pos_r        <= pos_nxt;
      vel_r        <= vel_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    c_r      <= c_nxt;
    spd_r    <= spd_nxt;
    mode_r   <= mode_nxt;
    y_r      <= y_nxt;
    fa_r     <= fa_nxt;
    fb_r     <= fb_nxt;
    fprod_r  <= fprod_nxt;
    p_r      <= p_nxt;
    second_r <= second_nxt;
    pprod_r  <= pprod_nxt;
    pm_r     <= pm_nxt;
    pn_r     <= pn_nxt;
    power_r  <= power_nxt;
    if (out_load) begin
      out_r.filtered_torque <= y_r;
      out_r.shaft_power     <= power_r;
    end
  end

  // Ring memory: registered read, one write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r <= ring_mem[np];
    end
    if (wr_en) begin
      ring_mem[ring_ptr_r] <= c_r;
    end
  end

  // Valid bits: unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_vld_r <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld_r <= ring_vld_r[np];
      end
      if (wr_en) begin
        ring_vld_r[ring_ptr_r] <= 1'b1;
      end
    end
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

endmodule

/* hw/rtl/torque_filter_bank_unit.sv */
// Torque filter bank with shaft power.
// Input channel: drive in_data and raise in_push; the item is taken on a
// clock edge where in_full is low. A two-item queue sits in front of the
// processing engine, so up to two items are taken while it is busy.
// Result channel: while out_empty is low, out_data holds the oldest result;
// raise out_pop to take it. When the receiver stalls, the finished result
// waits in the output slot, the engine holds its next result, and the
// input queue fills until in_full rises.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
// always high. Write only while no item is in flight.
// Path per item, from taking it off the queue to loading the output slot:
// no filter or a block-average sample that does not close the window goes
// straight to the power steps; the exponential filters first add one multiply
// and update, the alpha-beta tracker two; a window-closing block average and
// the running average (after its ring swap) wait on the divide by WINDOW.
// The single engine sets throughput: one item at a time.
// Reset (rst_n low, synchronous) clears all filter state, the queues and
// loads the register defaults (mode none).
module torque_filter_bank_unit #(
  parameter int unsigned WINDOW = tfb_pkg::WINDOW_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  tfb_pkg::in_item_t                    in_data,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output tfb_pkg::out_item_t                   out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tfb_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tfb_pkg::CFG_DATA_W-1:0]       cfg_data
);

  tfb_pkg::cfg_t    cfg_r;
  logic             q_valid, q_take;
  tfb_pkg::q_item_t q_data;

  assign cfg_ready = 1'b1;

  // Register writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.filter_mode     <= tfb_pkg::RST_FILTER_MODE;
      cfg_r.zero_offset     <= '0;
      cfg_r.exp_gain        <= tfb_pkg::RST_EXP_GAIN;
      cfg_r.adapt_threshold <= tfb_pkg::RST_ADAPT_THR;
      cfg_r.adapt_fast_gain <= tfb_pkg::RST_ADAPT_FAST;
      cfg_r.adapt_slow_gain <= tfb_pkg::RST_ADAPT_SLOW;
      cfg_r.ab_alpha        <= tfb_pkg::RST_AB_ALPHA;
      cfg_r.ab_beta         <= tfb_pkg::RST_AB_BETA;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tfb_pkg::REG_FILTER_MODE: cfg_r.filter_mode     <= cfg_data[2:0];
        tfb_pkg::REG_ZERO_OFFSET: cfg_r.zero_offset     <= $signed(cfg_data);
        tfb_pkg::REG_EXP_GAIN:    cfg_r.exp_gain        <= cfg_data[16:0];
        tfb_pkg::REG_ADAPT_THR:   cfg_r.adapt_threshold <= cfg_data[30:0];
        tfb_pkg::REG_ADAPT_FAST:  cfg_r.adapt_fast_gain <= cfg_data[16:0];
        tfb_pkg::REG_ADAPT_SLOW:  cfg_r.adapt_slow_gain <= cfg_data[16:0];
        tfb_pkg::REG_AB_ALPHA:    cfg_r.ab_alpha        <= cfg_data[24:0];
        tfb_pkg::REG_AB_BETA:     cfg_r.ab_beta         <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  tfb_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_valid (q_valid),
    .q_take  (q_take),
    .q_data  (q_data)
  );

  tfb_back #(.WINDOW(WINDOW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_take    (q_take),
    .q_data    (q_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

`ifndef SYNTH
  a_take_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> q_valid) else $error("engine took from an empty queue");
  a_full_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> q_valid) else $error("queue full but nothing offered");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty) else $error("result pending after reset");
`endif

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;

  localparam logic [tfb_pkg::CFG_IDX_W-1:0] REG_SPARE = 4'd11;  // no register behind it
  localparam int unsigned RING_LEN  = tfb_pkg::WINDOW_DEF;
  localparam int unsigned PHASES    = 16;
  localparam int unsigned PHASE_LEN = 50;
  localparam logic [63:0] POWER_CAP = 64'hFFFF_FFFF_FFFF;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [3:0]         idx;
    logic [31:0]        data;
    logic signed [31:0] torque;
    logic signed [31:0] speed;
    logic               typed;
    logic signed [31:0] ft;
    logic [47:0]        pw;
  } step_t;

  localparam int unsigned N_STEPS = 27;
  localparam step_t STEPS [N_STEPS] = '{
    '{ROW_ITEM, 4'd0, 32'd0, 32'sh0, 32'sh0, 1'b1, 32'sh0, 48'd0},
    '{ROW_ITEM, 4'd0, 32'd0, 32'sh7fffffff, 32'sh0, 1'b1, 32'sh7fffffff, 48'd0},
    '{ROW_ITEM, 4'd0, 32'd0, 32'sh80000000, 32'sh0, 1'b1, 32'sh80000000, 48'd0},
    '{ROW_ITEM, 4'd0, 32'd0, 32'sh0, 32'sh80000000, 1'b1, 32'sh0, 48'd0},
    '{ROW_ITEM, 4'd0, 32'd0, 32'sh7fffffff, 32'sh7fffffff, 1'b0, 32'sh0, 48'd0},
    '{ROW_ITEM, 4'd0, 32'd0, 32'sh80000000, 32'sh80000000, 1'b0, 32'sh0, 48'd0},
    '{ROW_CFG, tfb_pkg::REG_ZERO_OFFSET, 32'h7fffffff, 32'sh0, 32'sh0, 1'b0,
      32'sh0, 48'd0},
    '{ROW_ITEM, 4'd0, 32'd0, 32'sh7fffffff, 32'sh0, 1'b1, 32'sh7fffffff, 48'd0},
    '{ROW_CFG, tfb_pkg::REG_ZERO_OFFSET, 32'h80000000, 32'sh0, 32'sh0, 1'b0,
      32'sh0, 48'd0},
    '{ROW_ITEM, 4'd0, 32'd0, 32'sh80000000, 32'sh0, 1'b1, 32'sh80000000, 48'd0},
    '{ROW_CFG, tfb_pkg::REG_ZERO_OFFSET, 32'h00010000, 32'sh0, 32'sh0, 1'b0,
      32'sh0, 48'd0},
    '{ROW_CFG, tfb_pkg::REG_FILTER_MODE, 32'd6, 32'sh0, 32'sh0, 1'b0, 32'sh0, 48'd0},
    '{ROW_ITEM, 4'd0, 32'd0, 32'sh12345, 32'sh0, 1'b1, 32'sh22345, 48'd0},
    '{ROW_CFG, tfb_pkg::REG_FILTER_MODE, 32'd7, 32'sh0, 32'sh0, 1'b0, 32'sh0, 48'd0},
    '{ROW_ITEM, 4'd0, 32'd0, -32'sh30000, 32'sh5dc0000, 1'b0, 32'sh0, 48'd0},
    '{ROW_CFG, tfb_pkg::REG_FILTER_MODE, {29'd0, tfb_pkg::MODE_BLOCK}, 32'sh0, 32'sh0,
      1'b0, 32'sh0, 48'd0},
    '{ROW_ITEM, 4'd0, 32'd0, 32'sh50000, 32'sh10000, 1'b0, 32'sh0, 48'd0},
    '{ROW_CFG, tfb_pkg::REG_FILTER_MODE, {29'd0, tfb_pkg::MODE_RING}, 32'sh0, 32'sh0,
      1'b0, 32'sh0, 48'd0},
    '{ROW_ITEM, 4'd0, 32'd0, 32'sh7fffffff, 32'sh10000, 1'b0, 32'sh0, 48'd0},
    '{ROW_CFG, tfb_pkg::REG_EXP_GAIN, 32'h1ffff, 32'sh0, 32'sh0, 1'b0, 32'sh0, 48'd0},
    '{ROW_CFG, tfb_pkg::REG_FILTER_MODE, {29'd0, tfb_pkg::MODE_EXP}, 32'sh0, 32'sh0,
      1'b0, 32'sh0, 48'd0},
    '{ROW_ITEM, 4'd0, 32'd0, 32'sh7fff0000, 32'sh0, 1'b0, 32'sh0, 48'd0},
    '{ROW_CFG, tfb_pkg::REG_FILTER_MODE, {29'd0, tfb_pkg::MODE_ADAPT}, 32'sh0, 32'sh0,
      1'b0, 32'sh0, 48'd0},
    '{ROW_ITEM, 4'd0, 32'd0, 32'sh40000, 32'sh0, 1'b0, 32'sh0, 48'd0},
    '{ROW_CFG, tfb_pkg::REG_AB_ALPHA, 32'h1ffffff, 32'sh0, 32'sh0, 1'b0, 32'sh0, 48'd0},
    '{ROW_CFG, tfb_pkg::REG_FILTER_MODE, {29'd0, tfb_pkg::MODE_TRACK}, 32'sh0, 32'sh0,
      1'b0, 32'sh0, 48'd0},
    '{ROW_ITEM, 4'd0, 32'd0, 32'sh80000000, 32'sh0, 1'b0, 32'sh0, 48'd0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  tfb_pkg::in_item_t in_data = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  tfb_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [tfb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tfb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Filter state mirror
  tfb_pkg::cfg_t regs;
  logic signed [63:0] blk_sum, ring_sum;
  int unsigned blk_cnt, ring_ptr;
  logic signed [31:0] blk_avg, exp_v, adapt_v, trk_pos, trk_vel;
  logic signed [31:0] ring_buf [RING_LEN];

  tfb_pkg::out_item_t pending_results [$];
  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned mode_hits [8];
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;

  torque_filter_bank_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAIL torque_filter_bank_unit");
    $finish;
  end

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end
    if (x < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  // Divide by 2^n, round half up
  function automatic logic signed [63:0] round_div(input logic signed [63:0] x,
                                                   input int n);
    logic signed [63:0] biased;
    biased = x + (64'sd1 <<< (n - 1));
    return biased >>> n;
  endfunction

  function automatic logic signed [31:0] smooth(input logic signed [31:0] v,
                                                input logic signed [31:0] c,
                                                input logic [16:0] gain);
    logic signed [63:0] d;
    d = 64'(c) - 64'(v);
    return clamp32(64'(v) + round_div(d * $signed({47'd0, gain}), 16));
  endfunction

  function automatic logic [47:0] power_calc(input logic signed [31:0] c,
                                             input logic signed [31:0] s);
    logic [63:0] ac, as_, prod, acc;
    ac = c[31] ? 64'(-64'(c)) : 64'(c);
    as_ = s[31] ? 64'(-64'(s)) : 64'(s);
    prod = ac * as_;
    acc = (prod >> 32) * 64'(tfb_pkg::PWR_K) +
          (((prod & 64'hFFFF_FFFF) * 64'(tfb_pkg::PWR_K)) >> 32);
    acc = acc >> 16;
    return (acc > POWER_CAP) ? 48'hFFFF_FFFF_FFFF : acc[47:0];
  endfunction

  // Advance the selected filter and return the expected item
  function automatic tfb_pkg::out_item_t filter_step(input tfb_pkg::in_item_t it);
    tfb_pkg::out_item_t res;
    logic signed [31:0] c, y;
    logic signed [63:0] d, p, r;
    logic [16:0] g;
    c = clamp32(64'(it.torque_sample) + 64'(regs.zero_offset));
    mode_hits[regs.filter_mode]++;
    case (regs.filter_mode)
      tfb_pkg::MODE_BLOCK: begin
        blk_sum += 64'(c);
        blk_cnt++;
        if (blk_cnt >= RING_LEN) begin
          blk_avg = clamp32(blk_sum / 64'sd10);
          blk_sum = 0;
          blk_cnt = 0;
        end
        y = blk_avg;
      end
      tfb_pkg::MODE_RING: begin
        ring_ptr = (ring_ptr + 1 >= RING_LEN) ? 0 : ring_ptr + 1;
        ring_sum = ring_sum - 64'(ring_buf[ring_ptr]) + 64'(c);
        ring_buf[ring_ptr] = c;
        y = clamp32(ring_sum / 64'sd10);
      end
      tfb_pkg::MODE_EXP: begin
        exp_v = smooth(exp_v, c, regs.exp_gain);
        y = exp_v;
      end
      tfb_pkg::MODE_ADAPT: begin
        d = 64'(c) - 64'(adapt_v);
        if (d < 0) begin
          d = -d;
        end
        g = (d > 64'(regs.adapt_threshold)) ? regs.adapt_fast_gain : regs.adapt_slow_gain;
        adapt_v = smooth(adapt_v, c, g);
        y = adapt_v;
      end
      tfb_pkg::MODE_TRACK: begin
        p = 64'(trk_pos) + 64'(trk_vel);
        r = 64'(c) - p;
        trk_pos = clamp32(p + round_div(r * $signed({39'd0, regs.ab_alpha}), 24));
        trk_vel = clamp32(64'(trk_vel) + round_div(r * $signed({39'd0, regs.ab_beta}), 24));
        y = trk_pos;
      end
      default: y = c;
    endcase
    res.filtered_torque = y;
    res.shaft_power = power_calc(c, it.speed_sample);
    return res;
  endfunction

  function automatic void shadow_write(input logic [3:0] idx, input logic [31:0] val);
    case (idx)
      tfb_pkg::REG_FILTER_MODE: regs.filter_mode = val[2:0];
      tfb_pkg::REG_ZERO_OFFSET: regs.zero_offset = val;
      tfb_pkg::REG_EXP_GAIN:    regs.exp_gain = val[16:0];
      tfb_pkg::REG_ADAPT_THR:   regs.adapt_threshold = val[30:0];
      tfb_pkg::REG_ADAPT_FAST:  regs.adapt_fast_gain = val[16:0];
      tfb_pkg::REG_ADAPT_SLOW:  regs.adapt_slow_gain = val[16:0];
      tfb_pkg::REG_AB_ALPHA:    regs.ab_alpha = val[24:0];
      tfb_pkg::REG_AB_BETA:     regs.ab_beta = val[24:0];
      default: ;
    endcase
  endfunction

  // Hold the sender until every result is back
  task automatic drain();
    in_push <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [31:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    shadow_write(idx, val);
    cfg_valid <= 1'b0;
  endtask

  // Offer one item, with an optional gap first; predict on acceptance
  task automatic push_item(input tfb_pkg::in_item_t it, input logic typed,
                           input tfb_pkg::out_item_t want);
    tfb_pkg::out_item_t pred;
    while ($urandom_range(99, 0) < gap_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_full);
    pred = filter_step(it);
    pending_results.push_back(typed ? want : pred);
  endtask

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(7, 0))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2, 3: return $urandom();
      default: return 32'($signed($urandom_range(32'h1fffff, 0)) - 32'sh100000);
    endcase
  endfunction

  function automatic logic [31:0] pick_reg_value(input logic [3:0] idx);
    int unsigned sel;
    sel = $urandom_range(3, 0);
    case (idx)
      tfb_pkg::REG_ZERO_OFFSET:
        return (sel == 0) ? 32'h7fffffff : (sel == 1) ? 32'h80000000 :
               32'($signed($urandom_range(32'h3ffff, 0)) - 32'sh20000);
      tfb_pkg::REG_ADAPT_THR:
        return (sel == 0) ? 32'd0 : (sel == 1) ? 32'h7fffffff : $urandom_range(32'h80000, 0);
      tfb_pkg::REG_AB_ALPHA, tfb_pkg::REG_AB_BETA:
        return (sel == 0) ? 32'd0 : (sel == 1) ? 32'h1000000 : $urandom_range(32'h1ffffff, 0);
      default:
        return (sel == 0) ? 32'd0 : (sel == 1) ? 32'h10000 : $urandom_range(32'h1ffff, 0);
    endcase
  endfunction

  // Check each popped item against the oldest prediction; drive random stalls
  always @(posedge clk) begin
    tfb_pkg::out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected item: filtered_torque %0d shaft_power %0d",
               out_data.filtered_torque, out_data.shaft_power);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.filtered_torque !== want.filtered_torque) begin
          $error("filtered_torque expected %0d actual %0d",
                 want.filtered_torque, out_data.filtered_torque);
          errors++;
        end
        if (out_data.shaft_power !== want.shaft_power) begin
          $error("shaft_power expected %0d actual %0d",
                 want.shaft_power, out_data.shaft_power);
          errors++;
        end
      end
    end
    out_pop <= rst_n && ($urandom_range(99, 0) >= stall_pct);
  end

  initial begin
    tfb_pkg::in_item_t it;
    tfb_pkg::out_item_t want;
    logic [3:0] idx;
    int unsigned wait_cycles;

    regs = '{filter_mode: tfb_pkg::RST_FILTER_MODE, zero_offset: 32'sh0,
             exp_gain: tfb_pkg::RST_EXP_GAIN,
             adapt_threshold: tfb_pkg::RST_ADAPT_THR,
             adapt_fast_gain: tfb_pkg::RST_ADAPT_FAST,
             adapt_slow_gain: tfb_pkg::RST_ADAPT_SLOW,
             ab_alpha: tfb_pkg::RST_AB_ALPHA,
             ab_beta: tfb_pkg::RST_AB_BETA};
    blk_sum = 0; ring_sum = 0; blk_cnt = 0; ring_ptr = 0;
    blk_avg = 0; exp_v = 0; adapt_v = 0; trk_pos = 0; trk_vel = 0;
    foreach (ring_buf[i]) ring_buf[i] = 0;
    foreach (mode_hits[i]) mode_hits[i] = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed steps
    foreach (STEPS[i]) begin
      if (STEPS[i].kind == ROW_CFG) begin
        write_reg(STEPS[i].idx, STEPS[i].data);
      end else begin
        it.torque_sample = STEPS[i].torque;
        it.speed_sample = STEPS[i].speed;
        want.filtered_torque = STEPS[i].ft;
        want.shaft_power = STEPS[i].pw;
        push_item(it, STEPS[i].typed, want);
      end
    end
    // An index with no register behind it must change nothing
    write_reg(REG_SPARE, 32'hffffffff);
    push_item('{32'sh7fffffff, 32'sh7fffffff}, 1'b0, want);

    // Random phases: new settings, then items under one idling pattern
    for (int p = 0; p < PHASES; p++) begin
      write_reg(4'((p % 7) + 1), pick_reg_value(4'((p % 7) + 1)));
      for (int k = 0; k < 2; k++) begin
        idx = 4'($urandom_range(7, 1));
        write_reg(idx, pick_reg_value(idx));
      end
      write_reg(tfb_pkg::REG_FILTER_MODE, 32'(p % 8));
      case (p % 4)
        0: begin gap_pct = 0; stall_pct = 0; end
        1: begin gap_pct = 45; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 45; end
        default: begin gap_pct = 14; stall_pct = 14; end
      endcase
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (p == 5 && n == 25) begin
          drain();
        end
        it.torque_sample = pick_sample();
        it.speed_sample = pick_sample();
        push_item(it, 1'b0, want);
      end
    end

    in_push <= 1'b0;
    stall_pct = 0;
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (60) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d items never came out", pending_results.size());
      errors++;
    end

    $display("Checked %0d results; per filter mode: %0d %0d %0d %0d %0d %0d %0d %0d",
             results_seen, mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3],
             mode_hits[4], mode_hits[5], mode_hits[6], mode_hits[7]);
    if (errors == 0) begin
      $display("PASS torque_filter_bank_unit");
    end else begin
      $display("FAIL torque_filter_bank_unit");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/tfb_pkg.sv
hw/rtl/tfb_front.sv
hw/rtl/tfb_div.sv
hw/rtl/tfb_back.sv
hw/rtl/torque_filter_bank_unit.sv
bench/tb.sv
